// ===== src/box_tracker_region_hysteresis_macros.svh =====
// Assertion macros for the box tracker region hysteresis block.
// Used by the top level only; the checks compile away under SYNTHESIS.
`ifndef BOX_TRACKER_REGION_HYSTERESIS_MACROS_SVH
`define BOX_TRACKER_REGION_HYSTERESIS_MACROS_SVH

`ifndef SYNTHESIS
`define BTRH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btrh: check failed");
`define BTRH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btrh: check failed");
`else
`define BTRH_ASSERT_SAME(lbl, ante, cons)
`define BTRH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/btrh_pkg.sv =====
// Shared types, widths and constants of the box tracker region hysteresis block.
// No dependencies; used by every module of the block.
package btrh_pkg;

  localparam int FIELD_W = 16;
  localparam int DIM_W   = 13;
  localparam int PROP_W  = 9;
  localparam int ZONE_W  = 2;
  localparam int SUM_W   = DIM_W + 1;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  localparam int PROP_FRAC_BITS_DEF = 8;
  localparam int OUT_FRAC_BITS_DEF  = 14;
  localparam int COORD_BITS_DEF     = 16;

  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = DIM_W'(480);
  localparam logic [FIELD_W-1:0] WANTED_CLASS_RST = '0;
  localparam logic [FIELD_W-1:0] MIN_CONF_RST     = '0;
  localparam logic [PROP_W-1:0]  TARGET_PROP_RST  = PROP_W'(64);
  localparam logic [PROP_W-1:0]  SAFE_PROP_RST    = PROP_W'(128);

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH        = 3'd0,
    REG_IMAGE_HEIGHT       = 3'd1,
    REG_WANTED_CLASS       = 3'd2,
    REG_MIN_CONFIDENCE     = 3'd3,
    REG_TARGET_WIDTH_PROP  = 3'd4,
    REG_TARGET_HEIGHT_PROP = 3'd5,
    REG_SAFE_WIDTH_PROP    = 3'd6,
    REG_SAFE_HEIGHT_PROP   = 3'd7
  } reg_idx_t;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_OUTSIDE = 2'd0,
    ZONE_SAFE    = 2'd1,
    ZONE_TARGET  = 2'd2
  } zone_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0]          image_width;
    logic [DIM_W-1:0]          image_height;
    logic signed [FIELD_W-1:0] wanted_class;
    logic [FIELD_W-1:0]        min_confidence;
    logic [PROP_W-1:0]         target_width_prop;
    logic [PROP_W-1:0]         target_height_prop;
    logic [PROP_W-1:0]         safe_width_prop;
    logic [PROP_W-1:0]         safe_height_prop;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

endpackage

// ===== src/box_tracker_region_hysteresis.sv =====
// Box tracker with region hysteresis: top level, sequencer and result register.
// Depends on btrh_pkg, btrh_cfg, btrh_mul, btrh_div and the macros header.
//
// One detection box is taken per beat and gives one result beat. A box occupies
// the block until its result is written: a capture of the class filter, corner
// clamps and centre sums, an operand load, then OUT_FRAC_BITS + 1 steps of the
// two restoring dividers that produce move_x and move_y one quotient bit a cycle,
// and a finish state that writes the result register once it is free. The four
// bit-serial region multipliers finish within the divider steps. A result
// waiting in the output register does not block the next box until that box is
// ready to be written. Configuration is to be written only while idle.
module box_tracker_region_hysteresis #(
  parameter int PROP_FRAC_BITS = btrh_pkg::PROP_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS  = btrh_pkg::OUT_FRAC_BITS_DEF,
  parameter int COORD_BITS     = btrh_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [btrh_pkg::ADDR_W-1:0]         paddr,
  input  logic [btrh_pkg::DATA_W-1:0]         pwdata,
  output logic [btrh_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [btrh_pkg::FIELD_W-1:0] in_box_class,
  input  logic [btrh_pkg::FIELD_W-1:0]        in_box_confidence,
  input  logic signed [btrh_pkg::FIELD_W-1:0] in_left_x,
  input  logic signed [btrh_pkg::FIELD_W-1:0] in_top_y,
  input  logic signed [btrh_pkg::FIELD_W-1:0] in_right_x,
  input  logic signed [btrh_pkg::FIELD_W-1:0] in_bottom_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic                                out_should_move,
  output logic [btrh_pkg::ZONE_W-1:0]         out_zone,
  output logic signed [btrh_pkg::FIELD_W-1:0] out_move_x,
  output logic signed [btrh_pkg::FIELD_W-1:0] out_move_y
);
  import btrh_pkg::*;

  `include "box_tracker_region_hysteresis_macros.svh"

  localparam int CNT_W = $clog2(OUT_FRAC_BITS + 1);

  cfg_t      cfg;
  lane_ctl_t ctl;
  state_t    state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept;
  logic             res_load;
  logic             found_r;
  logic [SUM_W-1:0] cx2_r, cy2_r;
  logic             travelling_r;

  logic                      out_valid_r;
  logic                      out_found_r;
  logic                      out_move_r;
  zone_t                     out_zone_r;
  logic signed [FIELD_W-1:0] out_mx_r;
  logic signed [FIELD_W-1:0] out_my_r;

  logic [SUM_W-1:0] dist_x, dist_y;
  logic signed [SUM_W:0] dx, dy;
  logic tw_in, th_in, sw_in, sh_in;
  logic signed [FIELD_W-1:0] mx, my;
  zone_t zone;
  logic  move;

  function automatic logic [DIM_W-1:0] clamp_c(logic [FIELD_W-1:0] raw,
                                               logic [DIM_W-1:0] dim);
    logic [COORD_BITS-1:0] c;
    logic [DIM_W-1:0]      res;
    c = raw[COORD_BITS-1:0];
    if (c[COORD_BITS-1]) begin
      res = '0;
    end else if ((FIELD_W + 1)'(c) >= (FIELD_W + 1)'(dim)) begin
      res = (dim == '0) ? '0 : dim - DIM_W'(1);
    end else begin
      res = DIM_W'(c);
    end
    return res;
  endfunction

  btrh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept = in_valid & ~in_stall;

  // capture: class filter, clamped corners, doubled centres
  always_ff @(posedge clk) begin
    if (accept) begin
      found_r <= (in_box_class == cfg.wanted_class) &&
                 (in_box_confidence >= cfg.min_confidence);
      cx2_r <= SUM_W'(clamp_c(in_left_x, cfg.image_width)) +
               SUM_W'(clamp_c(in_right_x, cfg.image_width));
      cy2_r <= SUM_W'(clamp_c(in_top_y, cfg.image_height)) +
               SUM_W'(clamp_c(in_bottom_y, cfg.image_height));
    end
  end

  assign dx     = $signed({1'b0, cx2_r}) - $signed({2'b00, cfg.image_width});
  assign dy     = $signed({1'b0, cy2_r}) - $signed({2'b00, cfg.image_height});
  assign dist_x = dx[SUM_W] ? SUM_W'(-dx) : SUM_W'(dx);
  assign dist_y = dy[SUM_W] ? SUM_W'(-dy) : SUM_W'(dy);

  btrh_mul #(.PROP_FRAC_BITS(PROP_FRAC_BITS)) u_mul_tw (
    .clk (clk), .ctl (ctl), .prop (cfg.target_width_prop),
    .dim (cfg.image_width), .dev (dist_x), .hit (tw_in)
  );
  btrh_mul #(.PROP_FRAC_BITS(PROP_FRAC_BITS)) u_mul_th (
    .clk (clk), .ctl (ctl), .prop (cfg.target_height_prop),
    .dim (cfg.image_height), .dev (dist_y), .hit (th_in)
  );
  btrh_mul #(.PROP_FRAC_BITS(PROP_FRAC_BITS)) u_mul_sw (
    .clk (clk), .ctl (ctl), .prop (cfg.safe_width_prop),
    .dim (cfg.image_width), .dev (dist_x), .hit (sw_in)
  );
  btrh_mul #(.PROP_FRAC_BITS(PROP_FRAC_BITS)) u_mul_sh (
    .clk (clk), .ctl (ctl), .prop (cfg.safe_height_prop),
    .dim (cfg.image_height), .dev (dist_y), .hit (sh_in)
  );

  btrh_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_x (
    .clk (clk), .ctl (ctl), .invert (1'b0), .c2 (cx2_r),
    .dim (cfg.image_width), .result (mx)
  );
  btrh_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_y (
    .clk (clk), .ctl (ctl), .invert (1'b1), .c2 (cy2_r),
    .dim (cfg.image_height), .result (my)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_ITER;
        cnt_nxt   = '0;
      end
      ST_ITER: begin
        if (cnt_r == CNT_W'(OUT_FRAC_BITS)) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctl.load = 1'b0;
    ctl.step = 1'b0;
    in_stall = 1'b1;
    res_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_LOAD:   ctl.load = 1'b1;
      ST_ITER:   ctl.step = 1'b1;
      ST_FINISH: res_load = ~out_valid_r | ~out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  always_comb begin
    if (tw_in && th_in) begin
      zone = ZONE_TARGET;
    end else if (sw_in && sh_in) begin
      zone = ZONE_SAFE;
    end else begin
      zone = ZONE_OUTSIDE;
    end
  end

  assign move = ~((zone == ZONE_TARGET) || ((zone == ZONE_SAFE) && !travelling_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      travelling_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
        if (found_r) begin
          travelling_r <= move;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_found_r <= found_r;
      out_move_r  <= found_r & move;
      out_zone_r  <= found_r ? zone : ZONE_OUTSIDE;
      out_mx_r    <= found_r ? mx : '0;
      out_my_r    <= found_r ? my : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_should_move = out_move_r;
  assign out_zone        = out_zone_r;
  assign out_move_x      = out_mx_r;
  assign out_move_y      = out_my_r;

  `BTRH_ASSERT_NEXT(a_accept_loads, accept, state_r == ST_LOAD)
  `BTRH_ASSERT_NEXT(a_travel_held, !res_load, $stable(travelling_r))
  `BTRH_ASSERT_SAME(a_reject_zero, out_valid && !out_found, !out_should_move && out_zone == ZONE_OUTSIDE && out_move_x == 0 && out_move_y == 0)
  `BTRH_ASSERT_SAME(a_target_still, out_valid && out_found && out_zone == ZONE_TARGET, !out_should_move)

endmodule

// ===== src/btrh_cfg.sv =====
// APB register file of the box tracker: frame size, class filter, region proportions.
// Depends on btrh_pkg.
module btrh_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btrh_pkg::ADDR_W-1:0]   paddr,
  input  logic [btrh_pkg::DATA_W-1:0]   pwdata,
  output logic [btrh_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output btrh_pkg::cfg_t                cfg
);
  import btrh_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:        cfg_nxt.image_width        = pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:       cfg_nxt.image_height       = pwdata[DIM_W-1:0];
        REG_WANTED_CLASS:       cfg_nxt.wanted_class       = $signed(pwdata[FIELD_W-1:0]);
        REG_MIN_CONFIDENCE:     cfg_nxt.min_confidence     = pwdata[FIELD_W-1:0];
        REG_TARGET_WIDTH_PROP:  cfg_nxt.target_width_prop  = pwdata[PROP_W-1:0];
        REG_TARGET_HEIGHT_PROP: cfg_nxt.target_height_prop = pwdata[PROP_W-1:0];
        REG_SAFE_WIDTH_PROP:    cfg_nxt.safe_width_prop    = pwdata[PROP_W-1:0];
        REG_SAFE_HEIGHT_PROP:   cfg_nxt.safe_height_prop   = pwdata[PROP_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:        prdata = DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT:       prdata = DATA_W'(cfg_r.image_height);
      REG_WANTED_CLASS:       prdata = DATA_W'(cfg_r.wanted_class);
      REG_MIN_CONFIDENCE:     prdata = DATA_W'(cfg_r.min_confidence);
      REG_TARGET_WIDTH_PROP:  prdata = DATA_W'(cfg_r.target_width_prop);
      REG_TARGET_HEIGHT_PROP: prdata = DATA_W'(cfg_r.target_height_prop);
      REG_SAFE_WIDTH_PROP:    prdata = DATA_W'(cfg_r.safe_width_prop);
      REG_SAFE_HEIGHT_PROP:   prdata = DATA_W'(cfg_r.safe_height_prop);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width        <= IMAGE_WIDTH_RST;
      cfg_r.image_height       <= IMAGE_HEIGHT_RST;
      cfg_r.wanted_class       <= $signed(WANTED_CLASS_RST);
      cfg_r.min_confidence     <= MIN_CONF_RST;
      cfg_r.target_width_prop  <= TARGET_PROP_RST;
      cfg_r.target_height_prop <= TARGET_PROP_RST;
      cfg_r.safe_width_prop    <= SAFE_PROP_RST;
      cfg_r.safe_height_prop   <= SAFE_PROP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/btrh_mul.sv =====
// Bit-serial region lane: proportion times frame size by shift-and-add, then the
// strict bound test prop*dim > |2c - dim| << PROP_FRAC_BITS. Depends on btrh_pkg.
module btrh_mul #(
  parameter int PROP_FRAC_BITS = btrh_pkg::PROP_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  btrh_pkg::lane_ctl_t           ctl,
  input  logic [btrh_pkg::PROP_W-1:0]   prop,
  input  logic [btrh_pkg::DIM_W-1:0]    dim,
  input  logic [btrh_pkg::SUM_W-1:0]    dev,
  output logic                          hit
);
  import btrh_pkg::*;

  localparam int ACC_W = PROP_W + DIM_W;
  localparam int REF_W = SUM_W + PROP_FRAC_BITS;
  localparam int CMP_W = (ACC_W > REF_W) ? ACC_W : REF_W;

  logic [ACC_W-1:0]  acc_r,  acc_nxt;
  logic [ACC_W-1:0]  mcd_r,  mcd_nxt;
  logic [PROP_W-1:0] mpr_r,  mpr_nxt;
  logic [SUM_W-1:0]  dev_r,  dev_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcd_nxt = mcd_r;
    mpr_nxt = mpr_r;
    dev_nxt = dev_r;
    if (ctl.load) begin
      acc_nxt = '0;
      mcd_nxt = ACC_W'(dim);
      mpr_nxt = prop;
      dev_nxt = dev;
    end else if (ctl.step) begin
      if (mpr_r[0]) begin
        acc_nxt = acc_r + mcd_r;
      end
      mcd_nxt = mcd_r << 1;
      mpr_nxt = mpr_r >> 1;
    end
  end

  assign hit = CMP_W'(acc_r) > (CMP_W'(dev_r) << PROP_FRAC_BITS);

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mcd_r <= mcd_nxt;
    mpr_r <= mpr_nxt;
    dev_r <= dev_nxt;
  end

endmodule

// ===== src/btrh_div.sv =====
// Restoring divider lane, one quotient bit per cycle: normalises a doubled centre
// to Q(OUT_FRAC_BITS), round half away from zero, saturated. Depends on btrh_pkg.
module btrh_div #(
  parameter int OUT_FRAC_BITS = btrh_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  btrh_pkg::lane_ctl_t                 ctl,
  input  logic                                invert,
  input  logic [btrh_pkg::SUM_W-1:0]          c2,
  input  logic [btrh_pkg::DIM_W-1:0]          dim,
  output logic signed [btrh_pkg::FIELD_W-1:0] result
);
  import btrh_pkg::*;

  localparam int Q_W   = OUT_FRAC_BITS + 1;
  localparam int NUM_W = SUM_W + OUT_FRAC_BITS + 1;

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dvs_r, dvs_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;

  logic [DIM_W-2:0]        half;
  logic [DIM_W-1:0]        twice_half;
  logic signed [SUM_W:0]   diff;
  logic [SUM_W-1:0]        mag;
  logic                    ge;
  logic [Q_W-1:0]          lim;
  logic [Q_W-1:0]          qsat;
  logic signed [Q_W:0]     sq;

  assign half       = dim[DIM_W-1:1];
  assign twice_half = {half, 1'b0};
  assign diff = invert ? ($signed({2'b00, twice_half}) - $signed({1'b0, c2}))
                       : ($signed({1'b0, c2}) - $signed({2'b00, twice_half}));
  assign mag  = diff[SUM_W] ? SUM_W'(-diff) : SUM_W'(diff);
  assign ge   = rem_r >= dvs_r;

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (ctl.load) begin
      rem_nxt  = (NUM_W'(mag) << OUT_FRAC_BITS) + NUM_W'(half);
      dvs_nxt  = NUM_W'(twice_half) << OUT_FRAC_BITS;
      quo_nxt  = '0;
      neg_nxt  = diff[SUM_W];
      zero_nxt = (half == '0);
    end else if (ctl.step) begin
      if (ge) begin
        rem_nxt = rem_r - dvs_r;
      end
      quo_nxt = {quo_r[Q_W-2:0], ge};
      dvs_nxt = dvs_r >> 1;
    end
  end

  assign lim  = Q_W'(1) << OUT_FRAC_BITS;
  assign qsat = (quo_r > lim) ? lim : quo_r;
  assign sq   = neg_r ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});

  always_comb begin
    if (zero_r) begin
      result = '0;
    end else begin
      result = FIELD_W'(sq);
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

endmodule
